>>> rtl/core/mei_pkg.sv
`default_nettype none

package mei_pkg;

  // Fixed field widths of the result ports.
  localparam int unsigned FIELD_W = 31;
  localparam int unsigned COEF_W  = 32;

  // Coefficient seeds of the forward recurrence.
  localparam logic [COEF_W-1:0] COEF_ZERO = '0;
  localparam logic [COEF_W-1:0] COEF_ONE  = COEF_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MUL_S,
    ST_MUL_T,
    ST_UPD,
    ST_INV
  } mei_state_e;

  // Sequencer strobes to the datapath.
  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel_inv;
    logic finish_none;
    logic finish_inv;
  } mei_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/modular_inverse_ext_euclid_unit.sv
`default_nettype none

// Modular inverse by the extended Euclidean algorithm. Raise start for one
// cycle while busy is low to hand in operand_value_i and modulus_i; busy
// stays high until the word is finished, and the result word then shows on
// the result ports for exactly one cycle with result_valid_o high. The
// receiver cannot stall, so capture it in that cycle. Operands are taken in
// min(DATA_WIDTH-1, 31) bits (OP_W). Each Euclid step runs the check state,
// the shared bit-serial divider, and the states ST_MUL_S, ST_MUL_T and ST_UPD
// for the two coefficient products on one multiplier. When the gcd is one, a
// last pass of the same divider reduces x into 0..modulus-1. The worst case
// is 31-bit consecutive Fibonacci operands (45 steps, the first one a swap
// when the value is below the modulus).
// No gcd of one, or a zero modulus, gives inverse 0 with inverse_exists low.
module modular_inverse_ext_euclid_unit
  import mei_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [FIELD_W-1:0]       operand_value_i,
  input  wire logic [FIELD_W-1:0]       modulus_i,
  output logic                          result_valid_o,
  output logic [FIELD_W-1:0]            common_divisor_o,
  output logic signed [COEF_W-1:0]      bezout_x_o,
  output logic signed [COEF_W-1:0]      bezout_y_o,
  output logic [FIELD_W-1:0]            inverse_o,
  output logic                          inverse_exists_o
);

  // Operand width actually used.
  localparam int unsigned OP_W = (DATA_WIDTH - 1 < FIELD_W) ? DATA_WIDTH - 1 : FIELD_W;

  mei_state_e state_q, state_d;
  mei_ctrl_t  ctrl;

  // Remainder pair, modulus, and forward coefficient rows (s for x, t for y).
  logic [OP_W-1:0]   r0_q, r1_q, mod_q;
  logic [COEF_W-1:0] s0_q, s1_q, t0_q, t1_q;
  logic [OP_W-1:0]   quo_q, rem_q;
  logic [COEF_W-1:0] prod_q;

  // Result word.
  logic               valid_q;
  logic [OP_W-1:0]    gcd_q;
  logic [COEF_W-1:0]  x_q, y_q;
  logic [OP_W-1:0]    inv_q;
  logic               exists_q;

  // Shared divider.
  logic              div_done;
  logic [OP_W-1:0]   div_quo, div_rem;
  logic [OP_W-1:0]   div_a, div_b;

  logic              base_hit;
  logic              has_inv;
  logic              x_neg;
  logic [COEF_W-1:0] x_mag;
  logic [COEF_W-1:0] mul_b;
  logic [COEF_W-1:0] prod_c;
  logic [OP_W-1:0]   inv_c;

  assign base_hit = (r1_q == '0);
  assign has_inv  = (r0_q == OP_W'(1)) && (mod_q != '0);
  assign x_neg    = s0_q[COEF_W-1];
  assign x_mag    = x_neg ? (COEF_ZERO - s0_q) : s0_q;

  // Divider operands: Euclid step r0/r1, or final |x| mod m.
  assign div_a = ctrl.div_sel_inv ? x_mag[OP_W-1:0] : r0_q;
  assign div_b = ctrl.div_sel_inv ? mod_q : r1_q;

  mei_div #(
    .WIDTH(OP_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  // One multiplier, low COEF_W bits of q * s1 then q * t1 (wraps by design).
  assign mul_b  = (state_q == ST_MUL_S) ? s1_q : t1_q;
  assign prod_c = COEF_W'(quo_q) * mul_b;

  // Negative x folds to m - (|x| mod m), zero remainder stays zero.
  assign inv_c = (x_neg && (div_rem != '0)) ? (mod_q - div_rem)
               : (x_neg ? '0 : div_rem);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!base_hit)    state_d = ST_DIV;
        else if (has_inv) state_d = ST_INV;
        else              state_d = ST_IDLE;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_MUL_S;
      end
      ST_MUL_S: state_d = ST_MUL_T;
      ST_MUL_T: state_d = ST_UPD;
      ST_UPD:   state_d = ST_CHECK;
      ST_INV: begin
        if (div_done) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ctrl = '0;
    case (state_q)
      ST_IDLE: begin
        ctrl.load = start;
      end
      ST_CHECK: begin
        ctrl.div_start   = !base_hit || has_inv;
        ctrl.div_sel_inv = base_hit;
        ctrl.finish_none = base_hit && !has_inv;
      end
      ST_INV: begin
        ctrl.finish_inv = div_done;
      end
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= ctrl.finish_none || ctrl.finish_inv;
    end
  end

  // Datapath, no reset needed.
  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      r0_q  <= operand_value_i[OP_W-1:0];
      r1_q  <= modulus_i[OP_W-1:0];
      mod_q <= modulus_i[OP_W-1:0];
      s0_q  <= COEF_ONE;
      s1_q  <= COEF_ZERO;
      t0_q  <= COEF_ZERO;
      t1_q  <= COEF_ONE;
    end
    if ((state_q == ST_DIV) && div_done) begin
      quo_q <= div_quo;
      rem_q <= div_rem;
    end
    if (state_q == ST_MUL_S) begin
      prod_q <= prod_c;
    end
    if (state_q == ST_MUL_T) begin
      s0_q   <= s1_q;
      s1_q   <= s0_q - prod_q;
      prod_q <= prod_c;
    end
    if (state_q == ST_UPD) begin
      t0_q <= t1_q;
      t1_q <= t0_q - prod_q;
      r0_q <= r1_q;
      r1_q <= rem_q;
    end
    if (ctrl.finish_none || ctrl.finish_inv) begin
      gcd_q    <= r0_q;
      x_q      <= s0_q;
      y_q      <= t0_q;
      exists_q <= ctrl.finish_inv;
      inv_q    <= ctrl.finish_inv ? inv_c : '0;
    end
  end

  assign busy             = (state_q != ST_IDLE);
  assign result_valid_o   = valid_q;
  assign common_divisor_o = FIELD_W'(gcd_q);
  assign bezout_x_o       = $signed(x_q);
  assign bezout_y_o       = $signed(y_q);
  assign inverse_o        = FIELD_W'(inv_q);
  assign inverse_exists_o = exists_q;

endmodule

`default_nettype wire

>>> rtl/core/mei_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. done_o pulses when
// quotient_o / remainder_o are valid; they hold until the next start.
module mei_div #(
  parameter int unsigned WIDTH = 31
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WIDTH-1:0] dividend_i,
  input  wire logic [WIDTH-1:0] divisor_i,
  output logic                  done_o,
  output logic      [WIDTH-1:0] quotient_o,
  output logic      [WIDTH-1:0] remainder_o
);

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic             run_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [WIDTH-1:0] quo_q;
  logic [WIDTH-1:0] rem_q;
  logic [WIDTH-1:0] dvs_q;

  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             fits;
  logic [WIDTH-1:0] rem_d;

  assign trial = {rem_q, quo_q[WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = ~diff[WIDTH];
  assign rem_d = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(WIDTH);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[WIDTH-2:0], fits};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire
